FILE: rtl/core/vwbp_pkg.sv
// ----------------------------------------------------------------------------
// vwbp_pkg: shared definitions for the variable width bit packer
// Field widths, action codes and the packed input transfer layout.
// ----------------------------------------------------------------------------
package vwbp_pkg;

    localparam int unsigned ValueW   = 8;
    localparam int unsigned WidthW   = 4;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned InDataW  = 16;   // value + width, padded to bytes
    localparam int unsigned CountW   = 4;    // holds 1..8 free positions
    localparam int unsigned ShiftW   = 5;    // shift into a 16-bit window

    localparam logic ACTION_PUT   = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    localparam logic [CountW-1:0] FREE_ALL  = 4'd8;
    localparam logic [WidthW-1:0] WIDTH_MAX = 4'd8;

    typedef logic [InDataW-1:0] in_data_t;
    typedef logic [ByteW-1:0]   byte_t;

endpackage : vwbp_pkg

FILE: rtl/core/variable_width_bit_packer.sv
// ----------------------------------------------------------------------------
// variable_width_bit_packer: MSB-first packer of 1 to 8 bit fields into bytes
// Appends fields after the bits already held and emits each completed byte.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock unless the master side holds back,
// and gives at most one byte per transfer. A put (tuser = 0) carries a value
// in tdata[7:0] and its width in tdata[11:8]; the value is masked to that
// width and appended most significant bit first. A width of zero appends
// nothing, a width above eight counts as eight. When the held byte fills, it
// leaves on the master side and the held bits restart from the leftover of
// the field. A flush (tuser = 1) emits the partial byte with its unfilled low
// bits zero and keeps the state. An item waits in the input register and then
// loads the result register, from which its byte shows on the master side;
// both stages advance together whenever the result register is empty or
// being taken, so the sustained rate is one item per clock and is set only
// by back pressure on the master side.
module variable_width_bit_packer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  vwbp_pkg::in_data_t s_tdata,  // [7:0] field_value, [11:8] field_width, [15:12] zero
    input  logic             s_tuser,    // [0] action: 0 put, 1 flush
    output logic             m_tvalid,
    input  logic             m_tready,
    output vwbp_pkg::byte_t  m_tdata     // [7:0] out_byte
);
    import vwbp_pkg::*;

    // Input register stage
    logic              in_valid_reg;
    logic              in_action_reg;
    logic [ValueW-1:0] in_value_reg;
    logic [WidthW-1:0] in_width_reg;

    // Packer state
    byte_t             held_byte_reg, held_byte_next;
    logic [CountW-1:0] free_bits_reg, free_bits_next;

    // Result register
    logic              out_valid_reg;
    byte_t             out_byte_reg, out_byte_next;
    logic              emit;

    logic              advance;
    logic              take_in;

    // Datapath temporaries
    logic [WidthW-1:0]   width_eff;
    logic [ValueW-1:0]   value_masked;
    logic [ShiftW-1:0]   shift_amt;
    logic [2*ByteW-1:0]  window;
    logic [ShiftW-1:0]   used_bits;

    // Both stages move whenever the result register can take a new byte.
    assign advance  = !out_valid_reg || m_tready;
    assign take_in  = s_tvalid && s_tready;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_action_reg <= s_tuser;
            in_value_reg  <= s_tdata[ValueW-1:0];
            in_width_reg  <= s_tdata[ValueW +: WidthW];
        end
    end

    // Place the masked field in a 16-bit window whose upper byte is the held
    // byte; a field that straddles spills its tail into the lower byte.
    always_comb
    begin
        width_eff      = (in_width_reg > WIDTH_MAX) ? WIDTH_MAX : in_width_reg;
        value_masked   = in_value_reg
                         & ValueW'((9'd1 << width_eff) - 9'd1);
        shift_amt      = ShiftW'(5'd8 + {1'b0, free_bits_reg} - {1'b0, width_eff});
        window         = {held_byte_reg, 8'h00}
                         | (16'({8'h00, value_masked}) << shift_amt);
        used_bits      = ShiftW'(5'd8 - {1'b0, free_bits_reg} + {1'b0, width_eff});

        held_byte_next = held_byte_reg;
        free_bits_next = free_bits_reg;
        out_byte_next  = held_byte_reg;
        emit           = 1'b0;

        if (in_valid_reg)
        begin
            if (in_action_reg == ACTION_FLUSH)
            begin
                emit = 1'b1;
            end
            else if (width_eff != '0)
            begin
                if (used_bits >= 5'd8)
                begin
                    // byte complete: emit it, keep the spilled tail
                    emit           = 1'b1;
                    out_byte_next  = window[2*ByteW-1:ByteW];
                    held_byte_next = window[ByteW-1:0];
                    free_bits_next = CountW'(5'd16 - used_bits);
                end
                else
                begin
                    held_byte_next = window[2*ByteW-1:ByteW];
                    free_bits_next = CountW'(free_bits_reg - width_eff);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg <= '0;
            free_bits_reg <= FREE_ALL;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            held_byte_reg <= held_byte_next;
            free_bits_reg <= free_bits_next;
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_byte_reg <= out_byte_next;
        end
    end

    // Free count always names a real position count.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_bits_reg != '0 && free_bits_reg <= FREE_ALL)
        else $error("free bit count out of range");

    // An empty held byte carries no stray bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_bits_reg == FREE_ALL |-> held_byte_reg == '0)
        else $error("held byte not clear while empty");

    // A processed flush shows the held byte and leaves the state alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && in_action_reg == ACTION_FLUSH
        |=> m_tvalid && m_tdata == $past(held_byte_reg)
            && $stable(held_byte_reg) && $stable(free_bits_reg))
        else $error("flush result or state wrong");

    // A stalled item must not disturb the packer state.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(held_byte_reg) && $stable(free_bits_reg))
        else $error("state moved during stall");

endmodule : variable_width_bit_packer
